// File: sv/grouped_sample_playback_mixer_defines.svh
// ----------------------------------------------------------------------------
// gspm assertion macros
// shared property wrappers for the mixer block
// ----------------------------------------------------------------------------
`ifndef GROUPED_SAMPLE_PLAYBACK_MIXER_DEFINES_SVH
`define GROUPED_SAMPLE_PLAYBACK_MIXER_DEFINES_SVH

// implication checked on every edge outside reset
`define GSPM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define GSPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/gspm_pkg.sv
// ----------------------------------------------------------------------------
// gspm_pkg
// types, constants and command codes of the sample playback mixer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gspm_pkg;

   localparam int MAX_ENTRIES_DEF  = 8;
   localparam int SAMPLE_DEPTH_DEF = 4096;
   localparam logic [7:0] LEVEL_QUIET = 8'h80;
   localparam logic [7:0] LEVEL_IDLE  = 8'h00;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_START = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_WRITE = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [11:0] address;
      logic [12:0] sound_length;
      logic [7:0]  sample_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] pwm_level;
      logic       playing;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GROUP,
      ST_VRD,
      ST_VCHK,
      ST_SWAIT,
      ST_SACC,
      ST_GDIV,
      ST_GEND,
      ST_SHRD,
      ST_SHWR,
      ST_TDIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      logic [13:0] dividend;
      logic [6:0]  divisor;
   } div_req_type;

endpackage
`default_nettype wire

// File: sv/grouped_sample_playback_mixer.sv
// ----------------------------------------------------------------------------
// grouped_sample_playback_mixer
// add/start/tick/write sequencer over voice tables and a shared divider
// ----------------------------------------------------------------------------
// add, start and write finish in their accept cycle and keep busy low; a tick
// walks every voice of every started group, divides each group's sum by its
// live voices, copies later groups down when a group has no live voice left,
// and then divides the total by the number of mixed groups.
// busy is high while a tick runs; the result strobe lasts one cycle.
// synchronous reset clears group state; sample and voice tables are undefined.
`timescale 1ns / 1ps
`default_nettype none
`include "grouped_sample_playback_mixer_defines.svh"
module grouped_sample_playback_mixer
   import gspm_pkg::*;
#(
   parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
   parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_data,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);
   localparam int GW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int SLOTS = MAX_ENTRIES * MAX_ENTRIES;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int AW = $clog2(SAMPLE_DEPTH);
   localparam int VW = 12 + 13 + 13;

   state_type state_ff, state_in;
   logic [CW-1:0] gcount_ff, gcount_in;
   logic [CW-1:0] playg_ff, playg_in;
   logic [MAX_ENTRIES-1:0] started_ff, started_in;
   logic [CW-1:0] vcount_ff [MAX_ENTRIES];
   logic [CW-1:0] vcount_in [MAX_ENTRIES];
   logic [CW-1:0] g_ff, g_in;
   logic [CW-1:0] v_ff, v_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] comp_ff, comp_in;
   logic [11:0]   gsum_ff, gsum_in;
   logic [11:0]   total_ff, total_in;
   logic [CW-1:0] sg_ff, sg_in;
   logic [7:0]    level_ff, level_in;
   logic          rspv_ff, rspv_in;
   logic          playing_ff, playing_in;
   logic [12:0]   pos_ff, pos_in;

   // voice table
   logic          vt_we;
   logic [SW-1:0] vt_wa, vt_ra;
   logic [VW-1:0] vt_wd, vt_rd;
   logic [11:0]   vs;
   logic [12:0]   vl, vp;

   // sample memory
   logic          sm_we;
   logic [AW-1:0] sm_wa, sm_ra;
   logic [7:0]    sm_rd;

   div_req_type div_req;
   logic        div_busy;
   logic [13:0] div_q;

   assign {vs, vl, vp} = vt_rd;

   gspm_ram #(.WIDTH(VW), .DEPTH(SLOTS)) u_voice (
      .clock(clock), .wr_en(vt_we), .wr_addr(vt_wa), .wr_data(vt_wd),
      .rd_addr(vt_ra), .rd_data(vt_rd));

   gspm_ram #(.WIDTH(8), .DEPTH(SAMPLE_DEPTH)) u_sample (
      .clock(clock), .wr_en(sm_we), .wr_addr(sm_wa), .wr_data(req_data.sample_byte),
      .rd_addr(sm_ra), .rd_data(sm_rd));

   gspm_div u_div (.clock(clock), .reset(reset), .div_req(div_req),
      .busy(div_busy), .quotient(div_q));

   function automatic logic [SW-1:0] slot(input logic [CW-1:0] g, input logic [CW-1:0] v);
      logic [2*CW-1:0] k;
      k = (2*CW)'(g * MAX_ENTRIES + v);
      return k[SW-1:0];
   endfunction

   logic accept;
   logic last_open;
   assign accept = start && !busy;
   assign last_open = (gcount_ff != '0) && !started_ff[GW'(gcount_ff - 1'b1)];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.cmd == CMD_TICK) begin
               state_in = (playg_ff == '0) ? ST_DONE : ST_GROUP;
            end
         end
         ST_GROUP: begin
            if (g_ff >= gcount_ff) begin
               state_in = ST_TDIV;
            end else if (!started_ff[GW'(g_ff)]) begin
               state_in = ST_GROUP;
            end else begin
               state_in = ST_VRD;
            end
         end
         ST_VRD: state_in = (v_ff >= vcount_ff[GW'(g_ff)]) ? ST_GEND : ST_VCHK;
         ST_VCHK: state_in = (vp < vl) ? ST_SWAIT : ST_VRD;
         ST_SWAIT: state_in = ST_SACC;
         ST_SACC: state_in = ST_VRD;
         ST_GEND: state_in = (n_ff == '0) ? ST_SHRD : ST_GDIV;
         ST_GDIV: state_in = (div_busy) ? ST_GDIV : ST_GROUP;
         ST_SHRD: state_in = ST_SHWR;
         ST_SHWR: state_in = ST_SHRD;
         ST_TDIV: state_in = (div_busy || div_req.start) ? ST_TDIV : ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_SHRD && sg_ff + 1'b1 >= gcount_ff) begin
         state_in = ST_GROUP;
      end
   end

   // datapath and outputs
   logic [12:0] ap;
   logic        tdiv_go_ff, tdiv_go_in;
   always_comb begin
      gcount_in  = gcount_ff;
      playg_in   = playg_ff;
      started_in = started_ff;
      for (int i = 0; i < MAX_ENTRIES; i++) vcount_in[i] = vcount_ff[i];
      g_in = g_ff; v_in = v_ff; n_in = n_ff; comp_in = comp_ff;
      gsum_in = gsum_ff; total_in = total_ff; sg_in = sg_ff;
      level_in = level_ff; rspv_in = 1'b0; playing_in = playing_ff;
      pos_in = pos_ff; tdiv_go_in = 1'b0;
      vt_we = 1'b0; vt_wa = slot(g_ff, v_ff); vt_wd = {vs, vl, vp};
      vt_ra = slot(g_ff, v_ff);
      sm_we = 1'b0; sm_wa = AW'(req_data.address);
      ap = 13'(vs) + vp;
      sm_ra = AW'(ap);
      div_req = '{start: 1'b0, dividend: 14'(gsum_ff), divisor: 7'(n_ff)};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_ADD: begin
                     if (!last_open) begin
                        if (gcount_ff < CW'(MAX_ENTRIES)) begin
                           started_in[GW'(gcount_ff)] = 1'b0;
                           if (vcount_ff[GW'(gcount_ff)] != '0 || 1'b1) begin
                              vt_we = 1'b1;
                              vt_wa = slot(gcount_ff, '0);
                              vt_wd = {req_data.address, req_data.sound_length, 13'd0};
                              vcount_in[GW'(gcount_ff)] = CW'(1);
                           end
                           gcount_in = gcount_ff + 1'b1;
                        end
                     end else if (vcount_ff[GW'(gcount_ff - 1'b1)] < CW'(MAX_ENTRIES)) begin
                        vt_we = 1'b1;
                        vt_wa = slot(gcount_ff - 1'b1, vcount_ff[GW'(gcount_ff - 1'b1)]);
                        vt_wd = {req_data.address, req_data.sound_length, 13'd0};
                        vcount_in[GW'(gcount_ff - 1'b1)] =
                           vcount_ff[GW'(gcount_ff - 1'b1)] + 1'b1;
                     end
                  end
                  CMD_START: begin
                     if (last_open) begin
                        started_in[GW'(gcount_ff - 1'b1)] = 1'b1;
                        playg_in = playg_ff + 1'b1;
                     end
                  end
                  CMD_WRITE: sm_we = 1'b1;
                  CMD_TICK: begin
                     g_in = '0; v_in = '0; n_in = '0; gsum_in = '0;
                     comp_in = '0; total_in = '0;
                     playing_in = (playg_ff != '0);
                     level_in = LEVEL_IDLE;
                  end
                  default: ;
               endcase
            end
         end
         ST_GROUP: begin
            v_in = '0; n_in = '0; gsum_in = '0;
            if (g_ff < gcount_ff && !started_ff[GW'(g_ff)]) g_in = g_ff + 1'b1;
            vt_ra = slot(g_ff, '0);
         end
         ST_VRD: ;
         ST_VCHK: begin
            pos_in = vp;
            if (!(vp < vl)) begin
               v_in = v_ff + 1'b1;
               vt_ra = slot(g_ff, v_ff + 1'b1);
            end else begin
               vt_we = 1'b1;
               vt_wd = {vs, vl, vp + 13'd1};
            end
         end
         ST_SWAIT: ;
         ST_SACC: begin
            gsum_in = gsum_ff + 12'(sm_rd);
            n_in = n_ff + 1'b1;
            v_in = v_ff + 1'b1;
            vt_ra = slot(g_ff, v_ff + 1'b1);
         end
         ST_GEND: begin
            if (n_ff != '0) begin
               div_req.start = 1'b1;
            end else begin
               playg_in = playg_ff - 1'b1;
               sg_in = g_ff;
               v_in = '0;
            end
         end
         ST_GDIV: begin
            if (!div_busy) begin
               total_in = total_ff + 12'(div_q);
               comp_in = comp_ff + 1'b1;
               g_in = g_ff + 1'b1;
            end
         end
         ST_SHRD: begin
            vt_ra = slot(sg_ff + 1'b1, v_ff);
            if (sg_ff + 1'b1 >= gcount_ff) begin
               gcount_in = gcount_ff - 1'b1;
               started_in[GW'(sg_ff)] = 1'b0;
               vcount_in[GW'(sg_ff)] = '0;
            end
         end
         ST_SHWR: begin
            vt_we = 1'b1;
            vt_wa = slot(sg_ff, v_ff);
            vt_wd = vt_rd;
            if (v_ff + 1'b1 >= CW'(MAX_ENTRIES)) begin
               v_in = '0;
               started_in[GW'(sg_ff)] = started_ff[GW'(sg_ff + 1'b1)];
               vcount_in[GW'(sg_ff)] = vcount_ff[GW'(sg_ff + 1'b1)];
               sg_in = sg_ff + 1'b1;
            end else begin
               v_in = v_ff + 1'b1;
            end
         end
         ST_TDIV: begin
            div_req.dividend = 14'(total_ff);
            div_req.divisor = 7'(comp_ff);
            if (comp_ff == '0) begin
               level_in = LEVEL_QUIET;
            end else if (tdiv_go_ff == 1'b0 && !div_busy && level_ff == LEVEL_IDLE &&
                         pos_ff != 13'h1fff) begin
               div_req.start = 1'b1;
               tdiv_go_in = 1'b1;
               pos_in = 13'h1fff;
            end else if (!div_busy && !tdiv_go_ff) begin
               level_in = div_q[7:0];
            end
         end
         ST_DONE: rspv_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gcount_ff <= '0;
         playg_ff <= '0;
         started_ff <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) vcount_ff[i] <= '0;
         rspv_ff <= 1'b0;
         tdiv_go_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         gcount_ff <= gcount_in;
         playg_ff <= playg_in;
         started_ff <= started_in;
         for (int i = 0; i < MAX_ENTRIES; i++) vcount_ff[i] <= vcount_in[i];
         rspv_ff <= rspv_in;
         tdiv_go_ff <= tdiv_go_in;
      end
      g_ff <= g_in; v_ff <= v_in; n_ff <= n_in; comp_ff <= comp_in;
      gsum_ff <= gsum_in; total_ff <= total_in; sg_ff <= sg_in;
      level_ff <= level_in; playing_ff <= playing_in; pos_ff <= pos_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rspv_ff;
   assign rsp_data = '{pwm_level: level_ff, playing: playing_ff};

   `GSPM_ASSERT_IMP(a_groups_bound, clock, reset, 1'b1, gcount_ff <= CW'(MAX_ENTRIES), "group count overflow")
   `GSPM_ASSERT_IMP(a_play_bound, clock, reset, 1'b1, playg_ff <= gcount_ff, "playing exceeds groups")
   `GSPM_ASSERT_NEXT(a_busy_after_tick, clock, reset, accept && req_data.cmd == CMD_TICK, busy, "tick not taken")
   `GSPM_ASSERT_IMP(a_idle_quiet, clock, reset, rsp_valid && !rsp_data.playing, rsp_data.pwm_level == LEVEL_IDLE, "idle level nonzero")
endmodule
`default_nettype wire

// File: sv/gspm_ram.sv
// ----------------------------------------------------------------------------
// gspm_ram
// generic single-port-write ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gspm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: sv/gspm_div.sv
// ----------------------------------------------------------------------------
// gspm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gspm_div
   import gspm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output logic             busy,
   output logic [13:0]      quotient
);
   logic [13:0] quo_ff, quo_in;
   logic [6:0]  rem_ff, rem_in;
   logic [6:0]  dvs_ff, dvs_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [7:0]  trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[13]};
      if (div_req.start) begin
         quo_in = div_req.dividend;
         rem_in = '0;
         dvs_in = div_req.divisor;
         cnt_in = 4'd14;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 4'd1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 7'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[12:0], 1'b1};
         end else begin
            rem_in = trial[6:0];
            quo_in = {quo_ff[12:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// File: dv/grouped_sample_playback_mixer_tb.sv
// ----------------------------------------------------------------------------
// grouped_sample_playback_mixer testbench
// drives add, start, tick and write commands into the mixer; a scoreboard
// keeps a behavioral copy of groups, voices and sample memory and checks
// every tick result against it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module grouped_sample_playback_mixer_tb;
   import gspm_pkg::*;

   localparam int GROUPS = MAX_ENTRIES_DEF;
   localparam int DEPTH  = SAMPLE_DEPTH_DEF;
   localparam int TAIL_CYCLES = 1500;

   class mix_scoreboard;
      logic [7:0]  mem [DEPTH];
      int          n_groups;
      bit          started [GROUPS];
      int          n_voices [GROUPS];
      int          v_base [GROUPS][GROUPS];
      int          v_len [GROUPS][GROUPS];
      int          v_pos [GROUPS][GROUPS];
      int          n_playing;
      rsp_type     pending [$];
      int          errors;
      int          ticks;
      int          loud_ticks;

      function new();
         n_groups = 0;
         n_playing = 0;
         errors = 0;
         ticks = 0;
         loud_ticks = 0;
         for (int g = 0; g < GROUPS; g++) begin
            started[g] = 0;
            n_voices[g] = 0;
         end
      endfunction

      function void drop_group(int g);
         if (started[g] && n_playing > 0) n_playing--;
         for (int i = g; i + 1 < n_groups; i++) begin
            started[i] = started[i + 1];
            n_voices[i] = n_voices[i + 1];
            for (int v = 0; v < GROUPS; v++) begin
               v_base[i][v] = v_base[i + 1][v];
               v_len[i][v] = v_len[i + 1][v];
               v_pos[i][v] = v_pos[i + 1][v];
            end
         end
         n_groups--;
         started[n_groups] = 0;
         n_voices[n_groups] = 0;
      endfunction

      function int mix_level();
         int g;
         int mixed;
         int total;
         int sum;
         int live;
         g = 0;
         mixed = 0;
         total = 0;
         while (g < n_groups) begin
            if (!started[g]) begin
               g++;
               continue;
            end
            sum = 0;
            live = 0;
            for (int v = 0; v < n_voices[g]; v++) begin
               if (v_pos[g][v] < v_len[g][v]) begin
                  sum += mem[(v_base[g][v] + v_pos[g][v]) % DEPTH];
                  v_pos[g][v]++;
                  live++;
               end
            end
            if (live == 0) drop_group(g);
            else begin
               total += sum / live;
               mixed++;
               g++;
            end
         end
         return mixed ? total / mixed : int'(LEVEL_QUIET);
      endfunction

      function void note_beat(req_type r);
         rsp_type e;
         int g;
         case (r.cmd)
            CMD_ADD: begin
               if (n_groups == 0 || started[n_groups - 1]) begin
                  if (n_groups >= GROUPS) return;
                  started[n_groups] = 0;
                  n_voices[n_groups] = 0;
                  n_groups++;
               end
               g = n_groups - 1;
               if (n_voices[g] >= GROUPS) return;
               v_base[g][n_voices[g]] = r.address;
               v_len[g][n_voices[g]] = r.sound_length;
               v_pos[g][n_voices[g]] = 0;
               n_voices[g]++;
            end
            CMD_START: begin
               if (n_groups != 0 && !started[n_groups - 1]) begin
                  started[n_groups - 1] = 1;
                  n_playing++;
               end
            end
            CMD_WRITE: mem[r.address] = r.sample_byte;
            default: begin
               if (n_playing == 0) begin
                  e.pwm_level = LEVEL_IDLE;
                  e.playing = 0;
               end else begin
                  e.pwm_level = 8'(mix_level());
                  e.playing = 1;
               end
               pending.push_back(e);
            end
         endcase
      endfunction

      function void check_beat(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result pwm_level=%0h playing=%0b", a.pwm_level, a.playing);
            errors++;
            return;
         end
         e = pending.pop_front();
         ticks++;
         if (a.playing) loud_ticks++;
         if (a.pwm_level !== e.pwm_level) begin
            $error("pwm_level expected %0h actual %0h", e.pwm_level, a.pwm_level);
            errors++;
         end
         if (a.playing !== e.playing) begin
            $error("playing expected %0b actual %0b", e.playing, a.playing);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   mix_scoreboard board;
   int idle_pct;
   int beats_sent;

   grouped_sample_playback_mixer uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_data(req_data),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_beat(rsp_data);
   end

   task automatic send_beat(cmd_type c, int addr, int len, int data);
      req_type r;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_data <= req_type'($urandom);
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      r.cmd = c;
      r.address = 12'(addr);
      r.sound_length = 13'(len);
      r.sample_byte = 8'(data);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_beat(r);
      beats_sent++;
   endtask

   // fill a region so no voice ever reads unwritten memory
   task automatic fill_range(int base, int count);
      for (int i = 0; i < count; i++) send_beat(CMD_WRITE, base + i, 0, $urandom_range(255));
   endtask

   task automatic drain();
      int n;
      n = 0;
      start <= 1'b0;
      while (board.pending.size() != 0 && n < 100000) begin
         @(posedge clock);
         n++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // a well-formed playback: a group of voices inside [0,256), then ticks
   task automatic play_group();
      int nv;
      int nt;
      nv = $urandom_range(GROUPS + 1, 1);
      for (int v = 0; v < nv; v++) begin
         send_beat(CMD_ADD, $urandom_range(255 - 20), $urandom_range(20), $urandom);
      end
      if ($urandom_range(9) != 0) send_beat(CMD_START, $urandom, $urandom, $urandom);
      nt = $urandom_range(12);
      for (int t = 0; t < nt; t++) send_beat(CMD_TICK, $urandom, $urandom, $urandom);
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      idle_pct = 0;
      beats_sent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle tick, byte extremes, wrap, zero length, full lists
      send_beat(CMD_TICK, 0, 0, 0);
      send_beat(CMD_START, 0, 0, 0);
      fill_range(0, 256);
      send_beat(CMD_WRITE, 4095, 0, 8'hff);
      send_beat(CMD_WRITE, 4094, 0, 8'h00);
      send_beat(CMD_ADD, 4094, 4, 0);
      send_beat(CMD_ADD, 10, 0, 0);
      send_beat(CMD_START, 0, 0, 0);
      send_beat(CMD_START, 0, 0, 0);
      repeat (6) send_beat(CMD_TICK, 0, 0, 0);
      send_beat(CMD_ADD, 5, 0, 0);
      send_beat(CMD_START, 0, 0, 0);
      send_beat(CMD_TICK, 0, 0, 0);
      for (int g = 0; g < GROUPS + 1; g++) begin
         for (int v = 0; v < GROUPS + 1; v++) send_beat(CMD_ADD, g * 20 + v, 3 + v, 0);
         send_beat(CMD_START, 0, 0, 0);
      end
      repeat (12) send_beat(CMD_TICK, 0, 0, 0);
      drain();

      // random: mostly playback sequences over the written region
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: idle_pct = 0;
            1: idle_pct = 81;
            2: idle_pct = 0;
            default: idle_pct = 16;
         endcase
         while (beats_sent < 410 + phase * 50) begin
            case ($urandom_range(9))
               0: send_beat(CMD_WRITE, $urandom_range(255), 0, $urandom);
               1: send_beat(CMD_ADD, $urandom_range(200), $urandom_range(55, 20), $urandom);
               2: send_beat(CMD_WRITE, 4096 - 1 - $urandom_range(3839), 0, $urandom);
               3: send_beat(cmd_type'($urandom_range(2, 1)), $urandom, $urandom, $urandom);
               default: play_group();
            endcase
         end
         // long voices keep playing; run ticks until everything has finished
         while (board.n_playing != 0 && board.ticks < 40000) begin
            send_beat(CMD_TICK, $urandom, $urandom, $urandom);
         end
         drain();
      end

      $display("covered %0d commands, %0d ticks of which %0d with groups playing",
               beats_sent, board.ticks, board.loud_ticks);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #400ms;
      $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire
